// ===== hdl/cdt_pkg.sv =====
// Package for the cube-map direction-to-texel block.
// Holds face codes, fixed field widths and the sideband type; no dependencies.
package cdt_pkg;

  localparam int DIR_W   = 16;            // width of one direction component
  localparam int MAG_W   = DIR_W + 1;     // magnitude, holds 2^15
  localparam int FACE_W  = 3;
  localparam int TEXEL_W = 10;

  localparam int FACE_DIM_DEFAULT = 1024;

  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd0;
  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd5;

  // Control that rides along with an item through the pipeline.
  typedef struct packed {
    logic              valid;
    logic [FACE_W-1:0] face;
    logic              zero;
  } side_t;

endpackage

// ===== hdl/cubemap_direction_to_texel.sv =====
// Top level of the cube-map direction-to-texel block.
// Depends on cdt_pkg, cdt_front and cdt_div_cell.
//
// Maps a signed 3-D direction to a cube face and a texel on that face. The
// block takes one item per clock: an item is accepted at a rising edge with
// start high and busy low, and busy is high only while rst is asserted. Each
// item comes back exactly once, in order, on face/texel_i/texel_j/zero_vector
// with done high for a single cycle. Every item passes, whatever its data,
// through front-end stages A and B, the chain of division cells, each
// producing one quotient bit of both texel coordinates, and the output register.
// The receiver cannot stall the block, so the consumer must take
// every done cycle. Each coordinate is floor(FACE_DIM*(n+d)/(2d)) with d the
// major magnitude; a coordinate equal to FACE_DIM is clamped to FACE_DIM-1
// and then cut to 10 bits. Ties between magnitudes favor z, then y. An
// all-zero direction raises zero_vector with face and texels zero.
module cubemap_direction_to_texel import cdt_pkg::*; #(
  parameter int FACE_DIM = FACE_DIM_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [DIR_W-1:0]   dir_x,
  input  logic signed [DIR_W-1:0]   dir_y,
  input  logic signed [DIR_W-1:0]   dir_z,
  output logic                      done,
  output logic [FACE_W-1:0]         face,
  output logic [TEXEL_W-1:0]        texel_i,
  output logic [TEXEL_W-1:0]        texel_j,
  output logic                      zero_vector
);

  // quotient can equal FACE_DIM itself
  localparam int QW      = $clog2(FACE_DIM + 1);
  localparam int NUM_W   = MAG_W + QW;
  localparam int LATENCY = QW + 3;

  logic accept;

  // cell chain: index 0 is fed by the front end, index k+1 by cell k
  logic [MAG_W-1:0] den_c   [QW+1];
  logic [MAG_W-1:0] rem_i_c [QW+1];
  logic [MAG_W-1:0] rem_j_c [QW+1];
  logic [QW-1:0]    low_i_c [QW+1];
  logic [QW-1:0]    low_j_c [QW+1];
  logic [QW-1:0]    q_i_c   [QW+1];
  logic [QW-1:0]    q_j_c   [QW+1];
  side_t            side_c  [QW+1];

  logic [NUM_W-1:0] num_i, num_j;

  logic [QW-1:0] qc_i, qc_j;

  assign busy   = rst;
  assign accept = start && !busy;

  cdt_front #(
    .FACE_DIM (FACE_DIM),
    .QW       (QW),
    .NUM_W    (NUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .dx       (dir_x),
    .dy       (dir_y),
    .dz       (dir_z),
    .num_i    (num_i),
    .num_j    (num_j),
    .den      (den_c[0]),
    .side     (side_c[0])
  );

  // Upper bits of the numerator start as the remainder; they are below the
  // divisor because the quotient fits in QW bits. Lower bits shift in one a cell.
  assign rem_i_c[0] = num_i[NUM_W-1:QW];
  assign rem_j_c[0] = num_j[NUM_W-1:QW];
  assign low_i_c[0] = num_i[QW-1:0];
  assign low_j_c[0] = num_j[QW-1:0];
  assign q_i_c[0]   = '0;
  assign q_j_c[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    cdt_div_cell #(
      .QW (QW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .den_in    (den_c[k]),
      .rem_i_in  (rem_i_c[k]),
      .rem_j_in  (rem_j_c[k]),
      .low_i_in  (low_i_c[k]),
      .low_j_in  (low_j_c[k]),
      .q_i_in    (q_i_c[k]),
      .q_j_in    (q_j_c[k]),
      .side_in   (side_c[k]),
      .den_out   (den_c[k+1]),
      .rem_i_out (rem_i_c[k+1]),
      .rem_j_out (rem_j_c[k+1]),
      .low_i_out (low_i_c[k+1]),
      .low_j_out (low_j_c[k+1]),
      .q_i_out   (q_i_c[k+1]),
      .q_j_out   (q_j_c[k+1]),
      .side_out  (side_c[k+1])
    );
  end

  // Clamp a coordinate that lands on the far edge of the face.
  always_comb begin
    qc_i = (q_i_c[QW] >= QW'(FACE_DIM)) ? QW'(FACE_DIM - 1) : q_i_c[QW];
    qc_j = (q_j_c[QW] >= QW'(FACE_DIM)) ? QW'(FACE_DIM - 1) : q_j_c[QW];
  end

  // Output register; a zero direction forces face and texels to zero,
  // since its divisor was zero and the quotient is meaningless.
  always_ff @(posedge clk) begin
    zero_vector <= side_c[QW].zero;
    if (side_c[QW].zero) begin
      face    <= FACE_POS_Z;
      texel_i <= '0;
      texel_j <= '0;
    end else begin
      face    <= side_c[QW].face;
      texel_i <= TEXEL_W'(qc_i);
      texel_j <= TEXEL_W'(qc_j);
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_c[QW].valid;
    end
  end

  // Every accepted item later comes out with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted item did not emerge after the pipeline latency");

  // A zero direction reports zeros in every other field.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && zero_vector |-> face == FACE_POS_Z && texel_i == '0 && texel_j == '0)
    else $error("zero vector result carries nonzero fields");

  // Face code stays within the six faces.
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    done |-> face <= FACE_NEG_Y)
    else $error("face code out of range");

  // No result without a matching accepted item.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst, LATENCY) |-> $past(accept, LATENCY))
    else $error("result without a matching accepted item");

endmodule

// ===== hdl/cdt_front.sv =====
// Front end: major-axis selection, minor offsets, and scaling by the face size.
// Depends on cdt_pkg.
module cdt_front import cdt_pkg::*; #(
  parameter int FACE_DIM = FACE_DIM_DEFAULT,
  parameter int QW       = $clog2(FACE_DIM + 1),
  parameter int NUM_W    = MAG_W + QW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [DIR_W-1:0] dx,
  input  logic signed [DIR_W-1:0] dy,
  input  logic signed [DIR_W-1:0] dz,
  output logic [NUM_W-1:0]        num_i,
  output logic [NUM_W-1:0]        num_j,
  output logic [MAG_W-1:0]        den,
  output side_t                   side
);

  logic signed [MAG_W-1:0] xe, ye, ze;
  logic [MAG_W-1:0]        ax, ay, az;
  logic signed [MAG_W:0]   ni, nj;
  logic [MAG_W-1:0]        d;
  logic [FACE_W-1:0]       f;
  logic signed [MAG_W:0]   sum_i, sum_j;

  // stage A registers
  logic [MAG_W-1:0] a_si, a_sj, a_d;
  side_t            a_side;

  always_comb begin
    xe = {dx[DIR_W-1], dx};
    ye = {dy[DIR_W-1], dy};
    ze = {dz[DIR_W-1], dz};
    ax = xe[MAG_W-1] ? MAG_W'(-xe) : MAG_W'(xe);
    ay = ye[MAG_W-1] ? MAG_W'(-ye) : MAG_W'(ye);
    az = ze[MAG_W-1] ? MAG_W'(-ze) : MAG_W'(ze);
    if (ax > ay && ax > az) begin
      d  = ax;
      nj = -{ye[MAG_W-1], ye};
      if (xe[MAG_W-1]) begin
        f  = FACE_NEG_X;
        ni = {ze[MAG_W-1], ze};
      end else begin
        f  = FACE_POS_X;
        ni = -{ze[MAG_W-1], ze};
      end
    end else if (ax <= ay && ay > az) begin
      d  = ay;
      ni = {xe[MAG_W-1], xe};
      if (ye[MAG_W-1]) begin
        f  = FACE_NEG_Y;
        nj = -{ze[MAG_W-1], ze};
      end else begin
        f  = FACE_POS_Y;
        nj = {ze[MAG_W-1], ze};
      end
    end else begin
      d  = az;
      nj = -{ye[MAG_W-1], ye};
      if (ze[MAG_W-1]) begin
        f  = FACE_NEG_Z;
        ni = -{xe[MAG_W-1], xe};
      end else begin
        f  = FACE_POS_Z;
        ni = {xe[MAG_W-1], xe};
      end
    end
    // n + d lies in [0, 2d], so it fits the unsigned magnitude width
    sum_i = ni + $signed({1'b0, d});
    sum_j = nj + $signed({1'b0, d});
  end

  always_ff @(posedge clk) begin
    a_si        <= sum_i[MAG_W-1:0];
    a_sj        <= sum_j[MAG_W-1:0];
    a_d         <= d;
    a_side.face <= f;
    a_side.zero <= (ax == '0) && (ay == '0) && (az == '0);
    if (rst) begin
      a_side.valid <= 1'b0;
    end else begin
      a_side.valid <= in_valid;
    end
  end

  // stage B: scale by the face size, double the divisor
  always_ff @(posedge clk) begin
    num_i     <= NUM_W'(a_si) * NUM_W'(FACE_DIM);
    num_j     <= NUM_W'(a_sj) * NUM_W'(FACE_DIM);
    den       <= MAG_W'({a_d, 1'b0});
    side.face <= a_side.face;
    side.zero <= a_side.zero;
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= a_side.valid;
    end
  end

endmodule

// ===== hdl/cdt_div_cell.sv =====
// One restoring-division cell: one quotient bit per lane for both texel lanes.
// Depends on cdt_pkg.
module cdt_div_cell import cdt_pkg::*; #(
  parameter int QW = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [MAG_W-1:0] den_in,
  input  logic [MAG_W-1:0] rem_i_in,
  input  logic [MAG_W-1:0] rem_j_in,
  input  logic [QW-1:0]    low_i_in,
  input  logic [QW-1:0]    low_j_in,
  input  logic [QW-1:0]    q_i_in,
  input  logic [QW-1:0]    q_j_in,
  input  side_t            side_in,
  output logic [MAG_W-1:0] den_out,
  output logic [MAG_W-1:0] rem_i_out,
  output logic [MAG_W-1:0] rem_j_out,
  output logic [QW-1:0]    low_i_out,
  output logic [QW-1:0]    low_j_out,
  output logic [QW-1:0]    q_i_out,
  output logic [QW-1:0]    q_j_out,
  output side_t            side_out
);

  logic [MAG_W:0] sh_i, sh_j, dif_i, dif_j;
  logic           ge_i, ge_j;

  always_comb begin
    sh_i  = {rem_i_in, low_i_in[QW-1]};
    sh_j  = {rem_j_in, low_j_in[QW-1]};
    ge_i  = sh_i >= {1'b0, den_in};
    ge_j  = sh_j >= {1'b0, den_in};
    dif_i = ge_i ? sh_i - {1'b0, den_in} : sh_i;
    dif_j = ge_j ? sh_j - {1'b0, den_in} : sh_j;
  end

  always_ff @(posedge clk) begin
    den_out        <= den_in;
    rem_i_out      <= dif_i[MAG_W-1:0];
    rem_j_out      <= dif_j[MAG_W-1:0];
    low_i_out      <= {low_i_in[QW-2:0], 1'b0};
    low_j_out      <= {low_j_in[QW-2:0], 1'b0};
    q_i_out        <= {q_i_in[QW-2:0], ge_i};
    q_j_out        <= {q_j_in[QW-2:0], ge_j};
    side_out.face  <= side_in.face;
    side_out.zero  <= side_in.zero;
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
  end

endmodule
